>>> rtl/scroll_wheel_input_controller_top_assert.svh
// ----------------------------------------------------------------------------
// Scroll wheel controller assertion macros
// Checks sampled on clk; most of them are held off during reset.
// ----------------------------------------------------------------------------
`ifndef SCROLL_WHEEL_INPUT_CONTROLLER_TOP_ASSERT_SVH
`define SCROLL_WHEEL_INPUT_CONTROLLER_TOP_ASSERT_SVH

// Implication into the next cycle, held off while rst is high
`define SWIC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("swic check failed");

// Implication into the next cycle, checked during reset as well
`define SWIC_ASSERT_NEXT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("swic check failed");

`endif

>>> rtl/swic_pkg.sv
// ----------------------------------------------------------------------------
// Scroll wheel controller package
// Command, action and click codes, shared structs and the Gray lookup.
// ----------------------------------------------------------------------------
package swic_pkg;

  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_READ_ACTION = 3'd1;
  localparam logic [2:0] CMD_READ_INC    = 3'd2;
  localparam logic [2:0] CMD_READ_CLICK  = 3'd3;
  localparam logic [2:0] CMD_CLEAR       = 3'd4;

  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_UP         = 3'd1;
  localparam logic [2:0] ACT_DOWN       = 3'd2;
  localparam logic [2:0] ACT_SHORT      = 3'd3;
  localparam logic [2:0] ACT_LONG       = 3'd4;
  localparam logic [2:0] ACT_CLICK_UP   = 3'd5;
  localparam logic [2:0] ACT_CLICK_DOWN = 3'd6;
  localparam logic [2:0] ACT_DISCARDED  = 3'd7;

  localparam logic [2:0] CS_RELEASED      = 3'd0;
  localparam logic [2:0] CS_JUST_DETECTED = 3'd1;
  localparam logic [2:0] CS_DETECTED      = 3'd2;
  localparam logic [2:0] CS_JUST_RELEASED = 3'd3;
  localparam logic [2:0] CS_INVALID       = 3'd4;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_REVERSE  = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
  localparam logic [13:0] LONG_RESET     = 14'd1000;
  localparam logic [15:0] PRESS_MAX      = 16'hFFFF;

  localparam logic [1:0] PAT_ZERO = 2'b00;
  localparam logic [1:0] PAT_BOTH = 2'b11;

  typedef struct packed {
    logic tick;
    logic clear;
    logic zero;
  } wheel_ctl_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] click_state;
    logic [2:0] last_action;
    logic       scroll_zero;
  } click_res_t;

  // Gray sequence position of a pin pattern (bit 0 = A, bit 1 = B)
  function automatic logic [1:0] gray_index(input logic [1:0] pattern);
    logic [1:0] idx;
    case (pattern)
      2'b11:   idx = 2'd0;
      2'b01:   idx = 2'd1;
      2'b00:   idx = 2'd2;
      2'b10:   idx = 2'd3;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/swic_wheel.sv
// ----------------------------------------------------------------------------
// Scroll wheel quadrature decoder
// Tracks the Gray position, arms a direction at 00 and counts at 11.
// ----------------------------------------------------------------------------
module swic_wheel (
  input  logic               clk,
  input  logic               rst,
  input  swic_pkg::wheel_ctl_t ctl,
  input  logic               pin_a,
  input  logic               pin_b,
  input  logic               reverse,
  output logic [15:0]        scroll_count
);
  import swic_pkg::*;

  logic [1:0]  last_phase_index, last_phase_index_next;
  logic        armed_up, armed_up_next;
  logic        armed_down, armed_down_next;
  logic [15:0] scroll_count_next;
  logic [1:0]  pattern;
  logic [1:0]  idx;

  assign pattern = {pin_b, pin_a};
  assign idx     = gray_index(pattern);

  always_comb begin
    last_phase_index_next = last_phase_index;
    armed_up_next         = armed_up;
    armed_down_next       = armed_down;
    scroll_count_next     = scroll_count;
    if (ctl.tick) begin
      if (idx == last_phase_index + 2'd1) begin
        if (pattern == PAT_ZERO) begin
          armed_up_next = 1'b1;
        end else if (pattern == PAT_BOTH && armed_up) begin
          scroll_count_next = reverse ? scroll_count + 16'd1 : scroll_count - 16'd1;
          armed_up_next     = 1'b0;
          armed_down_next   = 1'b0;
        end
        last_phase_index_next = idx;
      end else if (idx == last_phase_index - 2'd1) begin
        if (pattern == PAT_ZERO) begin
          armed_down_next = 1'b1;
        end else if (pattern == PAT_BOTH && armed_down) begin
          scroll_count_next = reverse ? scroll_count - 16'd1 : scroll_count + 16'd1;
          armed_up_next     = 1'b0;
          armed_down_next   = 1'b0;
        end
        last_phase_index_next = idx;
      end
    end
    if (ctl.clear) begin
      armed_up_next   = 1'b0;
      armed_down_next = 1'b0;
    end
    if (ctl.zero || ctl.clear) begin
      scroll_count_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase_index <= 2'd0;
      armed_up         <= 1'b0;
      armed_down       <= 1'b0;
      scroll_count     <= 16'd0;
    end else begin
      last_phase_index <= last_phase_index_next;
      armed_up         <= armed_up_next;
      armed_down       <= armed_down_next;
      scroll_count     <= scroll_count_next;
    end
  end

endmodule

>>> rtl/swic_click.sv
// ----------------------------------------------------------------------------
// Scroll wheel click tracker
// Debounces the switch, times the press and classifies the pending action.
// ----------------------------------------------------------------------------
module swic_click (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [2:0]           command,
  input  logic                 pin_switch,
  input  logic                 ignore_scroll,
  input  logic [15:0]          scroll_count,
  input  logic [15:0]          debounce_ticks,
  input  logic [13:0]          long_press_ticks,
  output swic_pkg::click_res_t res
);
  import swic_pkg::*;

  typedef enum logic [4:0] {
    PH_REL  = 5'b00001,
    PH_JDET = 5'b00010,
    PH_DET  = 5'b00100,
    PH_JREL = 5'b01000,
    PH_INV  = 5'b10000
  } phase_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_REL:  code = CS_RELEASED;
      PH_JDET: code = CS_JUST_DETECTED;
      PH_DET:  code = CS_DETECTED;
      PH_JREL: code = CS_JUST_RELEASED;
      PH_INV:  code = CS_INVALID;
      default: code = CS_RELEASED;
    endcase
    return code;
  endfunction

  phase_t      phase, phase_next, phase_mid;
  logic [15:0] press_ticks, press_ticks_next;
  logic [15:0] hold_ticks, hold_ticks_next;
  logic        discard_release, discard_release_next;
  logic        penalty_active, penalty_active_next;
  logic [2:0]  recent_action, recent_action_next;
  logic [2:0]  ret;
  logic [15:0] inc_val;
  logic [15:0] thr;
  logic        inc_nz, inc_pos, inc_neg, over;

  assign inc_val = ignore_scroll ? 16'd0 : scroll_count;
  assign inc_nz  = |inc_val;
  assign inc_neg = inc_val[15];
  assign inc_pos = inc_nz && !inc_neg;
  assign thr     = {2'b00, long_press_ticks}
                 + (penalty_active ? {1'b0, long_press_ticks, 1'b0} : 16'd0);
  assign over    = hold_ticks > thr;

  always_comb begin
    phase_next           = phase;
    phase_mid            = phase;
    press_ticks_next     = press_ticks;
    hold_ticks_next      = hold_ticks;
    discard_release_next = discard_release;
    penalty_active_next  = penalty_active;
    recent_action_next   = recent_action;
    ret                  = ACT_NONE;
    res.action           = ACT_NONE;
    res.click_state      = CS_RELEASED;
    res.scroll_zero      = 1'b0;
    case (command)
      CMD_TICK: begin
        if (!pin_switch) begin
          if (phase != PH_INV) begin
            if (press_ticks == debounce_ticks && phase != PH_JREL) begin
              phase_mid = PH_JDET;
            end
            phase_next = phase_mid;
            if (press_ticks != PRESS_MAX) begin
              press_ticks_next = press_ticks + 16'd1;
            end
            if (phase_mid == PH_DET || phase_mid == PH_JDET) begin
              hold_ticks_next = hold_ticks + 16'd1;
            end
          end
        end else begin
          if (phase == PH_DET) begin
            phase_next = PH_JREL;
          end else if (phase != PH_JREL) begin
            hold_ticks_next = 16'd0;
            phase_next      = PH_REL;
          end
          press_ticks_next = 16'd0;
        end
      end
      CMD_READ_ACTION: begin
        // an invalid phase answers none and leaves everything alone
        if (phase != PH_INV) begin
          if (phase == PH_JDET) begin
            phase_mid = PH_DET;
          end
          phase_next = phase_mid;
          if (phase_mid == PH_JREL || inc_nz || over) begin
            if (over && !discard_release) begin
              ret = ACT_LONG;
            end else if (phase_mid == PH_JREL) begin
              if (!inc_nz) begin
                if (discard_release || penalty_active) begin
                  discard_release_next = 1'b0;
                  penalty_active_next  = 1'b0;
                  ret                  = ACT_DISCARDED;
                end else begin
                  ret = ACT_SHORT;
                end
              end
              phase_next = PH_REL;
            end else if (phase_mid == PH_DET) begin
              if (inc_pos) begin
                ret = ACT_CLICK_DOWN;
              end else if (inc_neg) begin
                ret = ACT_CLICK_UP;
              end
            end else begin
              if (inc_pos) begin
                ret = ACT_DOWN;
              end else if (inc_neg) begin
                ret = ACT_UP;
              end
            end
            hold_ticks_next = 16'd0;
            if (ret == ACT_LONG) begin
              discard_release_next = 1'b1;
            end else if (ret == ACT_CLICK_DOWN || ret == ACT_CLICK_UP) begin
              penalty_active_next = 1'b1;
            end
            res.scroll_zero = !ignore_scroll;
          end
          recent_action_next = ret;
          res.action         = ret;
        end
      end
      CMD_READ_CLICK: begin
        res.click_state = phase_code(phase);
        if (phase == PH_JDET) begin
          phase_next = PH_DET;
        end else if (phase == PH_JREL) begin
          phase_next = PH_REL;
        end
      end
      CMD_CLEAR: begin
        recent_action_next   = ACT_NONE;
        phase_next           = PH_INV;
        hold_ticks_next      = 16'd0;
        discard_release_next = 1'b0;
        penalty_active_next  = 1'b0;
      end
      default: begin
      end
    endcase
    res.last_action = recent_action_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_REL;
      press_ticks     <= 16'd0;
      hold_ticks      <= 16'd0;
      discard_release <= 1'b0;
      penalty_active  <= 1'b0;
      recent_action   <= ACT_NONE;
    end else if (step) begin
      phase           <= phase_next;
      press_ticks     <= press_ticks_next;
      hold_ticks      <= hold_ticks_next;
      discard_release <= discard_release_next;
      penalty_active  <= penalty_active_next;
      recent_action   <= recent_action_next;
    end
  end

endmodule

>>> rtl/scroll_wheel_input_controller_top.sv
// ----------------------------------------------------------------------------
// Scroll wheel input controller, top level
// Result: state and result register load together, result valid in the next cycle.
// Throughput: one item per cycle, unless a waiting result is stalled.
// Reset: synchronous; all state and the configuration registers return to defaults.
// ----------------------------------------------------------------------------
module scroll_wheel_input_controller_top (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  command,
  input  logic        pin_a,
  input  logic        pin_b,
  input  logic        pin_switch,
  input  logic        ignore_scroll,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  action,
  output logic signed [15:0] increment,
  output logic [2:0]  click_state,
  output logic [2:0]  last_action,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import swic_pkg::*;

  `include "scroll_wheel_input_controller_top_assert.svh"

  logic        accept;
  logic [15:0] debounce_ticks;
  logic        reverse_direction;
  logic [13:0] long_press_ticks;
  logic [15:0] scroll_count;
  wheel_ctl_t  wheel_ctl;
  click_res_t  click_res;

  // Hold the item side only while a finished result is still waiting
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // Configuration is always taken; the host writes only while the block idles (not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks    <= DEBOUNCE_RESET;
      reverse_direction <= 1'b0;
      long_press_ticks  <= LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ticks    <= cfg_data;
        REG_REVERSE:  reverse_direction <= cfg_data[0];
        REG_LONG:     long_press_ticks  <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  // Wheel counter: advance on a tick, drop to zero when a read consumes it or on a clear
  assign wheel_ctl.tick  = accept && command == CMD_TICK;
  assign wheel_ctl.clear = accept && command == CMD_CLEAR;
  assign wheel_ctl.zero  = accept && (command == CMD_READ_INC || click_res.scroll_zero);

  swic_wheel u_wheel (
    .clk          (clk),
    .rst          (rst),
    .ctl          (wheel_ctl),
    .pin_a        (pin_a),
    .pin_b        (pin_b),
    .reverse      (reverse_direction),
    .scroll_count (scroll_count)
  );

  // Click tracking and action classification, evaluated on the current state
  swic_click u_click (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .command          (command),
    .pin_switch       (pin_switch),
    .ignore_scroll    (ignore_scroll),
    .scroll_count     (scroll_count),
    .debounce_ticks   (debounce_ticks),
    .long_press_ticks (long_press_ticks),
    .res              (click_res)
  );

  // Result register: load on every accepted beat, clear valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action      <= click_res.action;
      increment   <= (command == CMD_READ_INC) ? scroll_count : 16'sd0;
      click_state <= click_res.click_state;
      last_action <= click_res.last_action;
    end
  end

  `SWIC_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !result_valid)
  `SWIC_ASSERT_NEXT(a_accept_loads, accept, result_valid)
  `SWIC_ASSERT_NEXT(a_action_only_on_read, accept && command != CMD_READ_ACTION, action == ACT_NONE)
  `SWIC_ASSERT_NEXT(a_incr_only_on_read, accept && command != CMD_READ_INC, increment == 16'sd0)
  `SWIC_ASSERT_NEXT(a_click_only_on_read, accept && command != CMD_READ_CLICK, click_state == CS_RELEASED)

endmodule

>>> tb/sv/scroll_wheel_input_controller_top_test.sv
// ----------------------------------------------------------------------------
// Scroll wheel input controller testbench
// Feeds command beats (ticks, reads, clears) into the controller and predicts
// every result beat with an untimed model of the quadrature decoder and the
// click state machine. Results are checked in order while idling, stalling
// and register settings change from phase to phase.
// ----------------------------------------------------------------------------
module scroll_wheel_input_controller_top_test;
  import swic_pkg::*;

  // One result beat as the controller presents it
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] increment;
    logic [2:0]  click_state;
    logic [2:0]  last_action;
  } reading_t;

  // Untimed model of the controller plus the queue of readings still owed
  class wheel_scoreboard;
    logic [15:0] debounce;
    logic        rev_dir;
    logic [13:0] long_thr;
    logic [1:0]  phase_pos;
    bit          arm_fwd;
    bit          arm_back;
    logic [15:0] wheel_count;
    logic [2:0]  click_st;
    logic [15:0] press_len;
    logic [15:0] hold_len;
    bit          drop_release;
    bit          penalty_on;
    logic [2:0]  latest_action;
    reading_t    expected_readings[$];
    int          errors;
    int          items_seen;
    int          readings_seen;

    function new();
      debounce      = DEBOUNCE_RESET;
      rev_dir       = 1'b0;
      long_thr      = LONG_RESET;
      phase_pos     = 2'd0;
      arm_fwd       = 1'b0;
      arm_back      = 1'b0;
      wheel_count   = '0;
      click_st      = CS_RELEASED;
      press_len     = '0;
      hold_len      = '0;
      drop_release  = 1'b0;
      penalty_on    = 1'b0;
      latest_action = ACT_NONE;
      errors        = 0;
      items_seen    = 0;
      readings_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_DEBOUNCE: debounce = data;
        REG_REVERSE:  rev_dir  = data[0];
        REG_LONG:     long_thr = data[13:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // Advance the model by one accepted item beat and queue its reading
    function void note_item(logic [2:0] cmd, logic a, logic b, logic sw, logic ign);
      logic [1:0] pat;
      logic [1:0] pos;
      logic [1:0] ahead;
      logic [1:0] behind;
      int         inc;
      int         thr;
      bit         over;
      reading_t   rec;
      rec = '0;
      items_seen++;
      case (cmd)
        CMD_TICK: begin
          pat = {b, a};
          case (pat)
            2'b11:   pos = 2'd0;
            2'b01:   pos = 2'd1;
            2'b00:   pos = 2'd2;
            default: pos = 2'd3;
          endcase
          ahead  = phase_pos + 2'd1;
          behind = phase_pos - 2'd1;
          // a skip or a repeat leaves the decoder alone
          if (pos == ahead) begin
            if (pat == PAT_ZERO) arm_fwd = 1'b1;
            else if (pat == PAT_BOTH && arm_fwd) begin
              wheel_count = rev_dir ? wheel_count + 16'd1 : wheel_count - 16'd1;
              arm_fwd  = 1'b0;
              arm_back = 1'b0;
            end
            phase_pos = pos;
          end else if (pos == behind) begin
            if (pat == PAT_ZERO) arm_back = 1'b1;
            else if (pat == PAT_BOTH && arm_back) begin
              wheel_count = rev_dir ? wheel_count - 16'd1 : wheel_count + 16'd1;
              arm_fwd  = 1'b0;
              arm_back = 1'b0;
            end
            phase_pos = pos;
          end
          // switch is active low
          if (!sw) begin
            if (click_st != CS_INVALID) begin
              if (press_len == debounce && click_st != CS_JUST_RELEASED)
                click_st = CS_JUST_DETECTED;
              if (press_len != PRESS_MAX) press_len = press_len + 16'd1;
              if (click_st == CS_DETECTED || click_st == CS_JUST_DETECTED)
                hold_len = hold_len + 16'd1;
            end
          end else begin
            if (click_st == CS_DETECTED) click_st = CS_JUST_RELEASED;
            else if (click_st != CS_JUST_RELEASED) begin
              hold_len = '0;
              click_st = CS_RELEASED;
            end
            press_len = '0;
          end
        end
        CMD_READ_ACTION: begin
          // an invalid click phase answers none and keeps the last action
          if (click_st != CS_INVALID) begin
            inc = ign ? 0 : int'($signed(wheel_count));
            if (click_st == CS_JUST_DETECTED) click_st = CS_DETECTED;
            thr = int'(long_thr);
            if (penalty_on) thr = thr * 3;
            over = int'(hold_len) > thr;
            if (click_st == CS_JUST_RELEASED || inc != 0 || over) begin
              if (over && !drop_release) rec.action = ACT_LONG;
              else if (click_st == CS_JUST_RELEASED) begin
                if (inc == 0) begin
                  if (drop_release || penalty_on) begin
                    drop_release = 1'b0;
                    penalty_on   = 1'b0;
                    rec.action   = ACT_DISCARDED;
                  end else begin
                    rec.action = ACT_SHORT;
                  end
                end
                click_st = CS_RELEASED;
              end else if (click_st == CS_DETECTED) begin
                if (inc > 0) rec.action = ACT_CLICK_DOWN;
                else if (inc < 0) rec.action = ACT_CLICK_UP;
              end else begin
                if (inc > 0) rec.action = ACT_DOWN;
                else if (inc < 0) rec.action = ACT_UP;
              end
              hold_len = '0;
              if (rec.action == ACT_LONG) drop_release = 1'b1;
              else if (rec.action == ACT_CLICK_DOWN || rec.action == ACT_CLICK_UP)
                penalty_on = 1'b1;
              if (!ign) wheel_count = '0;
            end
            latest_action = rec.action;
          end
        end
        CMD_READ_INC: begin
          rec.increment = wheel_count;
          wheel_count   = '0;
        end
        CMD_READ_CLICK: begin
          rec.click_state = click_st;
          if (click_st == CS_JUST_DETECTED) click_st = CS_DETECTED;
          else if (click_st == CS_JUST_RELEASED) click_st = CS_RELEASED;
        end
        CMD_CLEAR: begin
          latest_action = ACT_NONE;
          arm_fwd       = 1'b0;
          arm_back      = 1'b0;
          click_st      = CS_INVALID;
          hold_len      = '0;
          drop_release  = 1'b0;
          penalty_on    = 1'b0;
          wheel_count   = '0;
        end
        default: ;
      endcase
      rec.last_action = latest_action;
      expected_readings.push_back(rec);
    endfunction

    function void compare(string what, logic signed [31:0] want_v,
                          logic signed [31:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      end
    endfunction

    // Match one result beat against the oldest reading owed
    function void check_reading(logic [2:0] act, logic [15:0] incr, logic [2:0] cs,
                                logic [2:0] la);
      reading_t want;
      readings_seen++;
      if (expected_readings.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result beat with no reading pending, expected none, actual action %0d",
                   $time, act);
        return;
      end
      want = expected_readings.pop_front();
      compare("action", want.action, act);
      compare("increment", $signed(want.increment), $signed(incr));
      compare("click_state", want.click_state, cs);
      compare("last_action", want.last_action, la);
    endfunction
  endclass

  logic               clk;
  logic               rst           = 1'b1;
  logic               item_valid    = 1'b0;
  logic               item_stall;
  logic [2:0]         command       = CMD_TICK;
  logic               pin_a         = 1'b1;
  logic               pin_b         = 1'b1;
  logic               pin_switch    = 1'b1;
  logic               ignore_scroll = 1'b0;
  logic               result_valid;
  logic               result_stall  = 1'b0;
  logic [2:0]         action;
  logic signed [15:0] increment;
  logic [2:0]         click_state;
  logic [2:0]         last_action;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index     = REG_DEBOUNCE;
  logic [15:0]        cfg_data      = '0;

  wheel_scoreboard sb;

  // Knobs shared between the sender, the receiver and the phase sequencer
  int idle_pct  = 0;
  int stall_pct = 0;
  bit long_hold_req = 1'b0;
  int reg_writes = 0;

  // Random stimulus state: encoder position, turning sense and press timing
  logic [1:0] enc_pos      = 2'd0;
  bit         turn_fwd     = 1'b1;
  int         press_left   = 0;
  int         release_left = 0;
  int         cur_debounce = 100;
  int         cur_long     = 1000;

  scroll_wheel_input_controller_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .command       (command),
    .pin_a         (pin_a),
    .pin_b         (pin_b),
    .pin_switch    (pin_switch),
    .ignore_scroll (ignore_scroll),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .action        (action),
    .increment     (increment),
    .click_state   (click_state),
    .last_action   (last_action),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one item beat, idling first as the current phase asks, and hold
  // the payload until the controller takes it. Valid stays high on return
  // so that back-to-back beats need no second assignment in one step.
  task automatic send_beat(input logic [2:0] cmd, input logic a, input logic b,
                           input logic sw, input logic ign);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    command       <= cmd;
    pin_a         <= a;
    pin_b         <= b;
    pin_switch    <= sw;
    ignore_scroll <= ign;
    do @(posedge clk); while (item_stall);
    sb.note_item(cmd, a, b, sw, ign);
  endtask

  // Non-tick command; the pins carry noise the controller must ignore
  task automatic command_beat(input logic [2:0] cmd, input logic ign);
    send_beat(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), ign);
  endtask

  // Walk the encoder through one full detent, forwards or backwards
  task automatic turn(input bit fwd, input logic sw);
    logic [7:0] seq;
    logic [1:0] pat;
    seq = fwd ? 8'b01_00_10_11 : 8'b10_00_01_11;
    for (int k = 0; k < 4; k++) begin
      pat = seq[7 - 2 * k -: 2];
      send_beat(CMD_TICK, pat[0], pat[1], sw, 1'b0);
    end
  endtask

  // Drop valid and wait for every owed reading, then allow the pipe to settle
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  // Write all three registers while the controller is idle
  task automatic configure(input logic [15:0] deb, input logic rev, input logic [13:0] lng);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_REVERSE, {15'd0, rev});
    write_reg(REG_LONG, {2'd0, lng});
    cfg_valid    <= 1'b0;
    cur_debounce = int'(deb);
    cur_long     = int'(lng);
  endtask

  // One random beat: mostly well-formed encoder walks and press episodes,
  // with jumps, bounces and the odd clear or unused command mixed in
  task automatic random_item();
    int         r;
    logic [2:0] cmd;
    logic [1:0] pat;
    logic       sw;
    r = $urandom_range(0, 99);
    if (r < 68) cmd = CMD_TICK;
    else if (r < 82) cmd = CMD_READ_ACTION;
    else if (r < 88) cmd = CMD_READ_INC;
    else if (r < 95) cmd = CMD_READ_CLICK;
    else if (r < 97) cmd = CMD_CLEAR;
    else cmd = CMD_CLEAR + 3'($urandom_range(1, 3));
    if (cmd == CMD_TICK) begin
      if ($urandom_range(0, 99) < 8) turn_fwd = !turn_fwd;
      r = $urandom_range(0, 99);
      if (r < 85) enc_pos = turn_fwd ? enc_pos + 2'd1 : enc_pos - 2'd1;
      else if (r >= 92) enc_pos = 2'($urandom_range(0, 3));
      case (enc_pos)
        2'd0:    pat = 2'b11;
        2'd1:    pat = 2'b01;
        2'd2:    pat = 2'b00;
        default: pat = 2'b10;
      endcase
      if (press_left > 0) begin
        sw = 1'b0;
        press_left--;
      end else if (release_left > 0) begin
        sw = 1'b1;
        release_left--;
      end else begin
        press_left   = $urandom_range(0, cur_debounce + 3 * cur_long + 4);
        release_left = $urandom_range(1, 6);
        sw = 1'b1;
      end
      // occasional contact bounce
      if ($urandom_range(0, 99) < 5) sw = !sw;
      send_beat(cmd, pat[0], pat[1], sw, 1'($urandom_range(0, 1)));
    end else begin
      command_beat(cmd, 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: check every accepted result beat and drive stall, with a
  // long hold-off counted here when the sequencer asks for one
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        sb.check_reading(action, increment, click_state, last_action);
      if (long_hold_req) begin
        hold_left     = 300;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, part one: fastest debounce, long-press threshold of 1
    configure(16'd0, 1'b0, 14'd1);
    turn(1'b1, 1'b1);                    // forward detent counts down
    command_beat(CMD_READ_INC, 1'b0);
    turn(1'b0, 1'b1);                    // backward detent counts up
    command_beat(CMD_READ_ACTION, 1'b1); // ignore and keep the count
    command_beat(CMD_READ_ACTION, 1'b0);
    send_beat(CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b0); // skipped Gray state
    send_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 1'b0); // repeated state, press detected
    command_beat(CMD_READ_CLICK, 1'b0);
    send_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 1'b0); // hold past the threshold
    command_beat(CMD_READ_ACTION, 1'b0);         // long click
    send_beat(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0);
    command_beat(CMD_READ_ACTION, 1'b0);         // release after long is dropped
    drain();

    // Directed, part two: reversed wheel, longest threshold, click-scroll
    configure(16'd2, 1'b1, 14'h3FFF);
    turn(1'b1, 1'b0);
    command_beat(CMD_READ_ACTION, 1'b0);         // click-scroll sets the penalty
    send_beat(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0);
    command_beat(CMD_READ_ACTION, 1'b0);         // release under penalty
    command_beat(CMD_CLEAR, 1'b0);
    command_beat(CMD_READ_ACTION, 1'b0);         // invalid phase answers none
    send_beat(CMD_TICK, 1'b1, 1'b1, 1'b0, 1'b0); // pressed while invalid
    command_beat(CMD_READ_CLICK, 1'b0);
    send_beat(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b0); // release leaves invalid
    for (int k = 1; k <= 3; k++) command_beat(CMD_CLEAR + 3'(k), 1'b1);

    // Random phases: no idling, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          configure(16'd0, 1'b0, 14'd5);
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          configure(16'd3, 1'b1, 14'd1);
          idle_pct  = 84;
          stall_pct = 0;
        end
        2: begin
          configure(16'($urandom_range(0, 6)), 1'($urandom_range(0, 1)),
                    14'($urandom_range(2, 12)));
          idle_pct  = 0;
          stall_pct = 84;
        end
        default: begin
          configure(16'd1, 1'b0, 14'd3);
          idle_pct  = 26;
          stall_pct = 26;
        end
      endcase
      for (int n = 0; n < 212; n++) begin
        // fill the controller against a long receiver hold-off
        if (ph == 0 && n == 100) long_hold_req = 1'b1;
        // hold the sender until everything owed has arrived
        if (ph == 1 && n == 106) drain();
        random_item();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Run covered %0d item beats, %0d result beats and %0d register writes,",
             sb.items_seen, sb.readings_seen, reg_writes);
    $display("across directed corner cases and free-running, idle, stalled and mixed phases.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Timed out with %0d readings still owed", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
